### hdl/escaped_frame_port_demux_unit_defines.svh
// Assertion macros for the escaped frame port demux checker.
// Included by the checker file; the including scope provides clk and arst_n.
`ifndef ESCAPED_FRAME_PORT_DEMUX_UNIT_DEFINES_SVH
`define ESCAPED_FRAME_PORT_DEMUX_UNIT_DEFINES_SVH

// Concurrent check, disabled while reset is asserted
`define EFPD_ASSERT(name, prop, msg) \
	name: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);

// Concurrent check that also holds while reset is asserted
`define EFPD_ASSERT_ALWAYS(name, prop, msg) \
	name: assert property (@(posedge clk) prop) else $error(msg);

`endif

### hdl/efpd_pkg.sv
// Shared types, codes and constants of the escaped frame port demux.
// No dependencies; the modules and the checker import this package.
package efpd_pkg;

	localparam int DEF_MAX_PORTS   = 8;
	localparam int DEF_MAX_PAYLOAD = 32;

	// Payload count field, wide enough for the largest buffer size
	localparam int CNT_W = 6;
	// Queue between front and back; each slot owns one payload bank
	localparam int QDEPTH = 2;
	localparam int SLOT_W = 1;
	localparam int QCNT_W = 2;

	localparam logic [7:0] CH_LT    = 8'h3C; // '<'
	localparam logic [7:0] CH_LBR   = 8'h5B; // '['
	localparam logic [7:0] CH_D     = 8'h44; // 'D'
	localparam logic [7:0] CH_O     = 8'h4F; // 'O'
	localparam logic [7:0] CH_COMMA = 8'h2C; // ','
	localparam logic [7:0] CH_RBR   = 8'h5D; // ']'
	localparam logic [7:0] CH_GT    = 8'h3E; // '>'
	localparam logic [7:0] CH_ONE   = 8'h31; // '1'
	localparam logic [7:0] CH_BSL   = 8'h5C; // backslash
	localparam logic [7:0] CH_SP    = 8'h20; // space
	localparam logic [7:0] CH_PLUS  = 8'h2B; // '+'
	localparam logic [7:0] CH_MINUS = 8'h2D; // '-'
	localparam logic [7:0] CH_ZERO  = 8'h30; // '0'
	localparam logic [7:0] CH_NINE  = 8'h39; // '9'
	localparam logic [7:0] CH_TAB   = 8'h09; // first control white space
	localparam logic [7:0] CH_CR    = 8'h0D; // last control white space

	typedef enum logic [1:0] {
		OP_LINK     = 2'd0,
		OP_OPEN_REQ = 2'd1,
		OP_CLOSED   = 2'd2,
		OP_SENT     = 2'd3
	} op_t;

	typedef enum logic [1:0] {
		K_DATA      = 2'd0,
		K_OPEN_OK   = 2'd1,
		K_OPEN_FAIL = 2'd2,
		K_SUBMIT    = 2'd3
	} kind_t;

	typedef enum logic [2:0] {
		PS_IDLE,
		PS_OPEN,
		PS_CMD,
		PS_PORT,
		PS_DATA,
		PS_END
	} parse_t;

	typedef enum logic [1:0] {
		NS_SKIP,
		NS_DIGITS,
		NS_DONE,
		NS_NEG
	} num_t;

	typedef enum logic [1:0] {
		ST_CLOSED,
		ST_PENDING,
		ST_OPEN
	} pstat_t;

	// Finished frame, handed from front to back
	typedef struct packed {
		logic             is_open;
		logic             open_ok;
		logic [2:0]       port;
		logic [CNT_W-1:0] count;
		logic             submit;
	} frame_cmd_t;

	// Payload buffer write
	typedef struct packed {
		logic              en;
		logic [SLOT_W-1:0] slot;
		logic [CNT_W-1:0]  idx;
		logic [7:0]        data;
	} pay_wr_t;

	// Queue status seen by front and back
	typedef struct packed {
		logic              full;
		logic              empty;
		logic [SLOT_W-1:0] wr_slot;
		logic [SLOT_W-1:0] rd_slot;
	} q_status_t;

endpackage

### hdl/efpd_link_if.sv
// Input channel: one link byte or port operation per item.
// Standalone interface, no dependencies.
interface efpd_link_if;
	logic       valid;
	logic       ready;
	logic [1:0] operation;
	logic [7:0] link_byte;
	logic [2:0] port_select;

	modport source (output valid, output operation, output link_byte,
		output port_select, input ready);
	modport sink (input valid, input operation, input link_byte,
		input port_select, output ready);
endinterface

### hdl/efpd_result_if.sv
// Output channel: one result item per handshake.
// Standalone interface, no dependencies.
interface efpd_result_if;
	logic       valid;
	logic       ready;
	logic [1:0] kind;
	logic [2:0] port_out;
	logic [7:0] data_byte;
	logic       last;

	modport source (output valid, output kind, output port_out,
		output data_byte, output last, input ready);
	modport sink (input valid, input kind, input port_out,
		input data_byte, input last, output ready);
endinterface

### hdl/efpd_queue.sv
// Two-slot queue of finished frames between parser and emitter.
// Depends on efpd_pkg.
module efpd_queue (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   push,
	input  efpd_pkg::frame_cmd_t   push_cmd,
	input  logic                   pop,
	output efpd_pkg::frame_cmd_t   head,
	output efpd_pkg::q_status_t    status
);
	import efpd_pkg::*;

	frame_cmd_t          ent_q [QDEPTH];
	logic [SLOT_W-1:0]   wr_ptr_q;
	logic [SLOT_W-1:0]   rd_ptr_q;
	logic [QCNT_W-1:0]   cnt_q;

	// Store pushed frame
	always_ff @(posedge clk) begin
		if (push) begin
			ent_q[wr_ptr_q] <= push_cmd;
		end
	end

	// Advance pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == SLOT_W'(QDEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == SLOT_W'(QDEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (pop && !push) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

	assign head           = ent_q[rd_ptr_q];
	assign status.full    = (cnt_q == QCNT_W'(QDEPTH));
	assign status.empty   = (cnt_q == '0);
	assign status.wr_slot = wr_ptr_q;
	assign status.rd_slot = rd_ptr_q;

endmodule

### hdl/efpd_front.sv
// Frame parser: accepts items, tracks port state, buffers payload.
// Depends on efpd_pkg and efpd_link_if.
module efpd_front #(
	parameter int MAX_PORTS   = efpd_pkg::DEF_MAX_PORTS,
	parameter int MAX_PAYLOAD = efpd_pkg::DEF_MAX_PAYLOAD
) (
	input  logic                  clk,
	input  logic                  arst_n,
	efpd_link_if.sink             link,
	input  efpd_pkg::q_status_t   qs,
	output logic                  push,
	output efpd_pkg::frame_cmd_t  cmd,
	output efpd_pkg::pay_wr_t     wr
);
	import efpd_pkg::*;

	localparam int PW = (MAX_PORTS > 1) ? $clog2(MAX_PORTS) : 1;

	parse_t            st_q, st_n;
	num_t              ns_q, ns_n;
	logic              esc_q, esc_n;
	logic              is_open_q, is_open_n;
	logic [1:0]        dc_q, dc_n;
	logic [6:0]        pv_q, pv_n;
	logic [CNT_W-1:0]  cnt_q, cnt_n;
	logic              first_one_q, first_one_n;
	pstat_t            stat_q [MAX_PORTS];
	logic [MAX_PORTS-1:0] sent_q;

	logic              acc;
	op_t               op;
	logic [7:0]        c;
	logic              is_digit;
	logic [10:0]       pv_mac;
	logic [PW-1:0]     fidx;
	logic [PW-1:0]     oidx;
	logic              op_port_ok;
	logic              stat_we;
	logic [PW-1:0]     stat_idx;
	pstat_t            stat_val;
	logic              sent_we;
	logic [PW-1:0]     sent_idx;
	logic              sent_val;

	assign link.ready = !qs.full;
	assign acc        = link.valid && link.ready;
	assign op         = op_t'(link.operation);
	assign c          = link.link_byte;
	assign is_digit   = (c >= CH_ZERO) && (c <= CH_NINE);
	assign pv_mac     = {1'b0, pv_q, 3'b000} + {3'b000, pv_q, 1'b0} + {7'd0, c[3:0]};
	assign fidx       = pv_q[PW-1:0];
	assign oidx       = PW'({4'd0, link.port_select});
	assign op_port_ok = ({4'd0, link.port_select} < 7'(MAX_PORTS));

	// Next state of the parser and port table updates
	always_comb begin
		st_n        = st_q;
		ns_n        = ns_q;
		esc_n       = esc_q;
		is_open_n   = is_open_q;
		dc_n        = dc_q;
		pv_n        = pv_q;
		cnt_n       = cnt_q;
		first_one_n = first_one_q;
		push        = 1'b0;
		cmd         = '0;
		wr          = '0;
		stat_we     = 1'b0;
		stat_idx    = fidx;
		stat_val    = ST_CLOSED;
		sent_we     = 1'b0;
		sent_idx    = fidx;
		sent_val    = 1'b0;
		if (acc) begin
			if (op == OP_LINK) begin
				unique case (st_q)
					PS_IDLE: begin
						if (c == CH_LT) st_n = PS_OPEN;
					end
					PS_OPEN: begin
						if (c == CH_LBR) begin
							st_n = PS_CMD;
							dc_n = '0;
							pv_n = '0;
							ns_n = NS_SKIP;
						end else begin
							st_n = PS_IDLE;
						end
					end
					PS_CMD: begin
						if (c == CH_D || c == CH_O) begin
							is_open_n = (c == CH_O);
							st_n      = PS_PORT;
						end else begin
							st_n = PS_IDLE;
						end
					end
					PS_PORT: begin
						if (dc_q[1]) begin
							if (c == CH_COMMA) begin
								// negative non-zero port forces out of range
								if (ns_q == NS_NEG && pv_q != '0) pv_n = 7'h7F;
								cnt_n = '0;
								esc_n = 1'b0;
								st_n  = PS_DATA;
							end else begin
								st_n = PS_IDLE;
							end
						end else begin
							dc_n = dc_q + 1'b1;
							unique case (ns_q)
								NS_SKIP: begin
									if (c == CH_SP || (c >= CH_TAB && c <= CH_CR)) begin
										ns_n = NS_SKIP;
									end else if (c == CH_PLUS) begin
										ns_n = NS_DIGITS;
									end else if (c == CH_MINUS) begin
										ns_n = NS_NEG;
									end else if (is_digit) begin
										pv_n = {3'd0, c[3:0]};
										ns_n = NS_DIGITS;
									end else begin
										ns_n = NS_DONE;
									end
								end
								NS_DIGITS, NS_NEG: begin
									if (is_digit) pv_n = pv_mac[6:0];
									else ns_n = NS_DONE;
								end
								NS_DONE: ns_n = NS_DONE;
							endcase
						end
					end
					PS_DATA: begin
						if (!esc_q && c == CH_BSL) begin
							esc_n = 1'b1;
						end else if (!esc_q && c == CH_RBR) begin
							st_n = PS_END;
						end else begin
							esc_n = 1'b0;
							if (cnt_q < CNT_W'(MAX_PAYLOAD)) begin
								wr.en   = 1'b1;
								wr.slot = qs.wr_slot;
								wr.idx  = cnt_q;
								wr.data = c;
								cnt_n   = cnt_q + 1'b1;
								if (cnt_q == '0) first_one_n = (c == CH_ONE);
							end
						end
					end
					PS_END: begin
						st_n = PS_IDLE;
						if (c == CH_GT && pv_q < 7'(MAX_PORTS)) begin
							cmd.port  = pv_q[2:0];
							cmd.count = cnt_q;
							if (!is_open_q) begin
								// data frame: bytes, then submit unless a send was flagged
								cmd.submit = !sent_q[fidx];
								push       = (cnt_q != '0) || !sent_q[fidx];
								sent_we    = 1'b1;
								sent_val   = 1'b0;
							end else if (stat_q[fidx] == ST_PENDING) begin
								cmd.is_open = 1'b1;
								cmd.open_ok = (cnt_q != '0) && first_one_q;
								push        = 1'b1;
								stat_we     = 1'b1;
								stat_val    = cmd.open_ok ? ST_OPEN : ST_CLOSED;
							end
						end
					end
					default: st_n = PS_IDLE;
				endcase
			end else if (op_port_ok) begin
				stat_idx = oidx;
				sent_idx = oidx;
				unique case (op)
					OP_OPEN_REQ: begin
						stat_we  = 1'b1;
						stat_val = ST_PENDING;
						sent_we  = 1'b1;
						sent_val = 1'b0;
					end
					OP_CLOSED: begin
						stat_we  = 1'b1;
						stat_val = ST_CLOSED;
					end
					OP_SENT: begin
						sent_we  = 1'b1;
						sent_val = 1'b1;
					end
					default: ;
				endcase
			end
		end
	end

	// Parser and port table registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q        <= PS_IDLE;
			ns_q        <= NS_SKIP;
			esc_q       <= 1'b0;
			is_open_q   <= 1'b0;
			dc_q        <= '0;
			pv_q        <= '0;
			cnt_q       <= '0;
			first_one_q <= 1'b0;
			sent_q      <= '0;
			for (int i = 0; i < MAX_PORTS; i++) begin
				stat_q[i] <= ST_CLOSED;
			end
		end else begin
			st_q        <= st_n;
			ns_q        <= ns_n;
			esc_q       <= esc_n;
			is_open_q   <= is_open_n;
			dc_q        <= dc_n;
			pv_q        <= pv_n;
			cnt_q       <= cnt_n;
			first_one_q <= first_one_n;
			if (stat_we) stat_q[stat_idx] <= stat_val;
			if (sent_we) sent_q[sent_idx] <= sent_val;
		end
	end

endmodule

### hdl/efpd_back.sv
// Result emitter: payload banks and a two-stage output pipeline.
// Depends on efpd_pkg and efpd_result_if.
module efpd_back #(
	parameter int MAX_PAYLOAD = efpd_pkg::DEF_MAX_PAYLOAD
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  efpd_pkg::pay_wr_t     wr,
	input  efpd_pkg::frame_cmd_t  head,
	input  efpd_pkg::q_status_t   qs,
	output logic                  pop,
	efpd_result_if.source         result
);
	import efpd_pkg::*;

	localparam int IW    = (MAX_PAYLOAD > 1) ? $clog2(MAX_PAYLOAD) : 1;
	localparam int DEPTH = 1 << (SLOT_W + IW);

	logic [7:0]        mem [DEPTH];
	logic [CNT_W-1:0]  idx_q;

	logic              v_s1;
	kind_t             kind_s1;
	logic [2:0]        port_s1;
	logic              last_s1;
	logic              isdata_s1;
	logic [7:0]        rdata_s1;

	logic              v_s2;
	kind_t             kind_s2;
	logic [2:0]        port_s2;
	logic [7:0]        data_s2;
	logic              last_s2;

	logic              res_data;
	logic              res_last;
	kind_t             res_kind;
	logic              s1_adv;
	logic              issue;

	// Classify the next result of the head frame
	always_comb begin
		res_data = !head.is_open && (idx_q < head.count);
		if (head.is_open) begin
			res_last = 1'b1;
			res_kind = head.open_ok ? K_OPEN_OK : K_OPEN_FAIL;
		end else begin
			res_last = head.submit ? (idx_q == head.count) : (idx_q == head.count - 1'b1);
			res_kind = res_data ? K_DATA : K_SUBMIT;
		end
	end

	assign s1_adv = v_s1 && (!v_s2 || result.ready);
	assign issue  = !qs.empty && (!v_s1 || s1_adv);
	assign pop    = issue && res_last;

	// Payload banks: write from the parser, registered read for the emitter
	always_ff @(posedge clk) begin
		if (wr.en) begin
			mem[{wr.slot, wr.idx[IW-1:0]}] <= wr.data;
		end
		if (issue) begin
			rdata_s1 <= mem[{qs.rd_slot, idx_q[IW-1:0]}];
		end
	end

	// Load result info with the read
	always_ff @(posedge clk) begin
		if (issue) begin
			kind_s1   <= res_kind;
			port_s1   <= head.port;
			last_s1   <= res_last;
			isdata_s1 <= res_data;
		end
		if (s1_adv) begin
			kind_s2 <= kind_s1;
			port_s2 <= port_s1;
			data_s2 <= isdata_s1 ? rdata_s1 : 8'd0;
			last_s2 <= last_s1;
		end
	end

	// Advance result index and stage valids
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idx_q <= '0;
			v_s1  <= 1'b0;
			v_s2  <= 1'b0;
		end else begin
			if (issue) begin
				idx_q <= res_last ? '0 : idx_q + 1'b1;
			end
			if (issue) v_s1 <= 1'b1;
			else if (s1_adv) v_s1 <= 1'b0;
			if (s1_adv) v_s2 <= 1'b1;
			else if (result.ready) v_s2 <= 1'b0;
		end
	end

	assign result.valid     = v_s2;
	assign result.kind      = kind_s2;
	assign result.port_out  = port_s2;
	assign result.data_byte = data_s2;
	assign result.last      = last_s2;

endmodule

### hdl/escaped_frame_port_demux_unit.sv
// Top level of the escaped frame port demux: parser, frame queue, emitter.
// Depends on efpd_pkg, efpd_link_if, efpd_result_if and the three submodules.
//
//   channel  dir  handshake    payload
//   link     in   valid/ready  operation, link_byte, port_select
//   result   out  valid/ready  kind, port_out, data_byte, last
//
// The parser takes one item per cycle while the queue is not full. A finished
// frame is queued; the emitter issues one result per cycle while result.ready is
// high, the first passing the queue and both output stages after the closing '>'.
// A data frame of N unescaped bytes takes N+8 input items; with two queue slots
// one frame drains while the next is parsed.
// link.ready drops only while both queue slots (payload banks) hold frames.
// Reset clears parser, port table and queue at once; no clearing pass.
module escaped_frame_port_demux_unit #(
	parameter int MAX_PORTS   = efpd_pkg::DEF_MAX_PORTS,
	parameter int MAX_PAYLOAD = efpd_pkg::DEF_MAX_PAYLOAD
) (
	input  logic          clk,
	input  logic          arst_n,
	efpd_link_if.sink     link,
	efpd_result_if.source result
);
	import efpd_pkg::*;

	frame_cmd_t  push_cmd;
	frame_cmd_t  head;
	q_status_t   qs;
	pay_wr_t     wr;
	logic        push;
	logic        pop;

	efpd_front #(
		.MAX_PORTS   (MAX_PORTS),
		.MAX_PAYLOAD (MAX_PAYLOAD)
	) u_front (
		.clk    (clk),
		.arst_n (arst_n),
		.link   (link),
		.qs     (qs),
		.push   (push),
		.cmd    (push_cmd),
		.wr     (wr)
	);

	efpd_queue u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.push_cmd (push_cmd),
		.pop      (pop),
		.head     (head),
		.status   (qs)
	);

	efpd_back #(
		.MAX_PAYLOAD (MAX_PAYLOAD)
	) u_back (
		.clk    (clk),
		.arst_n (arst_n),
		.wr     (wr),
		.head   (head),
		.qs     (qs),
		.pop    (pop),
		.result (result)
	);

endmodule

### hdl/efpd_checker.sv
// Port-level checks of the escaped frame port demux, bound to the top level.
// Depends on efpd_pkg and escaped_frame_port_demux_unit_defines.svh.
`include "escaped_frame_port_demux_unit_defines.svh"

module efpd_checker (
	input logic       clk,
	input logic       arst_n,
	input logic       res_valid,
	input logic       res_ready,
	input logic [1:0] res_kind,
	input logic [2:0] res_port,
	input logic [7:0] res_data,
	input logic       res_last
);
	import efpd_pkg::*;

	// Hold a stalled result
	`EFPD_ASSERT(a_res_hold, res_valid && !res_ready |=> res_valid && $stable(res_kind) && $stable(res_port) && $stable(res_data) && $stable(res_last), "stalled result changed")

	// No result while reset is applied
	`EFPD_ASSERT_ALWAYS(a_rst_quiet, !arst_n |-> !res_valid, "result valid during reset")

	// Only data results carry a byte
	`EFPD_ASSERT(a_zero_byte, res_valid && res_kind != K_DATA |-> res_data == 8'd0, "non-data result carries a byte")

	// Open replies and submit requests close their item's results
	`EFPD_ASSERT(a_tail_last, res_valid && (res_kind == K_OPEN_OK || res_kind == K_OPEN_FAIL || res_kind == K_SUBMIT) |-> res_last, "tail result without last")

endmodule

bind escaped_frame_port_demux_unit efpd_checker u_efpd_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.res_valid (result.valid),
	.res_ready (result.ready),
	.res_kind  (result.kind),
	.res_port  (result.port_out),
	.res_data  (result.data_byte),
	.res_last  (result.last)
);
